// ===== sv/longest_prefix_route_table_defines.svh =====
// Assertion macros of the route table checker.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route table check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route table check failed");

`endif

// ===== sv/lprt_pkg.sv =====
// Package: types, codes and helpers of the longest prefix route table.
package lprt_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int DEVICES_DEFAULT = 15;

    // Slot index carried along the chain; wide enough for the largest table.
    localparam int SLOT_W = 8;

    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_FLUSH  = 2'd1;
    localparam logic [1:0] FN_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADDEV  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOROUTE = 2'd3;

    // Loopback route held in slot 0 after reset.
    localparam logic [31:0] LOOP_NET  = 32'h7F00_0000;
    localparam logic [31:0] LOOP_MASK = 32'hFF00_0000;
    localparam logic [5:0]  LOOP_PLEN = 6'd8;
    localparam logic [3:0]  LOOP_DEV  = 4'd1;

    // Query word and running scan results, handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [1:0]        func;
        logic [31:0]       dest;
        logic [31:0]       mask;
        logic [31:0]       net;
        logic [31:0]       gw;
        logic [3:0]        dev;
        logic [5:0]        plen;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
        logic              best_found;
        logic [5:0]        best_len;
        logic [3:0]        best_dev;
        logic [31:0]       best_gw;
    } chain_t;

    // Slot write broadcast at the end of an add.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [31:0]       net;
        logic [31:0]       mask;
        logic [31:0]       gw;
        logic [3:0]        dev;
        logic [5:0]        plen;
    } slot_wr_t;

    // Count of leading one bits of a mask: locate the highest zero bit.
    function automatic logic [5:0] lead_ones(input logic [31:0] m);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i <= 31; i++)
        begin
            if (!m[i])
                n = 6'(31 - i);
        end
        return n;
    endfunction

endpackage

// ===== sv/lprt_req_if.sv =====
// Request channel interface of the route table.
interface lprt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] dest_addr;
    logic [31:0] addr_mask;
    logic [31:0] gateway;
    logic [3:0]  device;

    modport source (output valid, output func, output dest_addr, output addr_mask,
                    output gateway, output device, input ready);
    modport sink   (input valid, input func, input dest_addr, input addr_mask,
                    input gateway, input device, output ready);
endinterface

// ===== sv/lprt_rsp_if.sv =====
// Response channel interface of the route table.
interface lprt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  out_device;
    logic [31:0] next_hop;

    modport source (output valid, output status, output out_device, output next_hop,
                    input ready);
    modport sink   (input valid, input status, input out_device, input next_hop,
                    output ready);
endinterface

// ===== sv/lprt_cell.sv =====
// One route slot: holds its entry, folds it into the passing query word and clears it when its device is flushed.
module lprt_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lprt_pkg::chain_t  chain_in,
    input  lprt_pkg::slot_wr_t wr,
    output lprt_pkg::chain_t  chain_out
);
    import lprt_pkg::*;

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

    logic [3:0]  dev_reg,  dev_next;
    logic [31:0] net_reg,  net_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] gw_reg,   gw_next;
    logic [5:0]  plen_reg, plen_next;
    chain_t      out_reg,  out_next;

    logic live;
    assign live = (dev_reg != 4'd0);

    always_comb
    begin
        dev_next  = dev_reg;
        net_next  = net_reg;
        mask_next = mask_reg;
        gw_next   = gw_reg;
        plen_next = plen_reg;
        out_next  = chain_in;
        if (wr.en && wr.idx == MY_IDX)
        begin
            dev_next  = wr.dev;
            net_next  = wr.net;
            mask_next = wr.mask;
            gw_next   = wr.gw;
            plen_next = wr.plen;
        end
        if (chain_in.valid)
        begin
            unique case (chain_in.func)
                FN_ADD:
                begin
                    if (!chain_in.hit && live && net_reg == chain_in.net &&
                        mask_reg == chain_in.mask)
                    begin
                        out_next.hit     = 1'b1;
                        out_next.hit_idx = MY_IDX;
                    end
                    if (!chain_in.free_found && !live)
                    begin
                        out_next.free_found = 1'b1;
                        out_next.free_idx   = MY_IDX;
                    end
                end
                FN_FLUSH:
                begin
                    if (dev_reg == chain_in.dev)
                        dev_next = 4'd0;
                end
                FN_LOOKUP:
                begin
                    if (live && (chain_in.dest & mask_reg) == net_reg &&
                        (!chain_in.best_found || plen_reg > chain_in.best_len))
                    begin
                        out_next.best_found = 1'b1;
                        out_next.best_len   = plen_reg;
                        out_next.best_dev   = dev_reg;
                        out_next.best_gw    = gw_reg;
                    end
                end
                default:
                begin
                    out_next = chain_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg  <= (IDX == 0) ? LOOP_DEV  : 4'd0;
            net_reg  <= (IDX == 0) ? LOOP_NET  : 32'd0;
            mask_reg <= (IDX == 0) ? LOOP_MASK : 32'd0;
            gw_reg   <= 32'd0;
            plen_reg <= (IDX == 0) ? LOOP_PLEN : 6'd0;
            out_reg  <= '0;
        end
        else
        begin
            dev_reg  <= dev_next;
            net_reg  <= net_next;
            mask_reg <= mask_next;
            gw_reg   <= gw_next;
            plen_reg <= plen_next;
            out_reg  <= out_next;
        end
    end

    assign chain_out = out_reg;

endmodule

// ===== sv/longest_prefix_route_table.sv =====
// Top level of the longest prefix route table: cell chain and control.
//
//   channel | dir | fields                                        | word
//   req     | in  | func, dest_addr, addr_mask, gateway, device   | one operation
//   rsp     | out | status, out_device, next_hop                  | one result
//
// A request word is taken when req.valid and req.ready are high at a clock edge.
// Its result passes the head register, the chain of ENTRIES slot cells, the tail
// register and the output register before it is offered. The next request word
// can be taken from the cycle its predecessor's result appears, so only one word
// is in flight at a time. rst_n loads the loopback route 127.0.0.0/8 on device 1
// into slot 0 at once. A stalled result holds in the output register; the
// finished scan waits in the tail register until that register frees.
module longest_prefix_route_table #(
    parameter int ENTRIES = lprt_pkg::ENTRIES_DEFAULT,
    parameter int DEVICES = lprt_pkg::DEVICES_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    lprt_req_if.sink  req,
    lprt_rsp_if.source rsp
);
    import lprt_pkg::*;

    localparam logic [8:0] DEV_LIMIT = 9'(DEVICES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t      state_reg;
    chain_t      head_reg,  head_next;
    chain_t      tail_reg;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [1:0]  status_reg;
    logic [3:0]  out_device_reg;
    logic [31:0] next_hop_reg;

    chain_t      chain_w [ENTRIES+1];
    slot_wr_t    wr;

    logic        accept;
    logic        out_free;
    logic        bad_dev;
    logic [1:0]  res_status;
    logic [3:0]  res_device;
    logic [31:0] res_hop;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // Launch a query word for exactly one cycle.
    always_comb
    begin
        head_next = '0;
        if (accept)
        begin
            head_next.valid = 1'b1;
            head_next.func  = req.func;
            head_next.dest  = req.dest_addr;
            head_next.mask  = req.addr_mask;
            head_next.net   = req.dest_addr & req.addr_mask;
            head_next.gw    = req.gateway;
            head_next.dev   = req.device;
            head_next.plen  = lead_ones(req.addr_mask);
        end
    end

    // Drop the result once taken; raise it when the finished scan moves out.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (state_reg == S_DONE && out_free)
            rsp_valid_next = 1'b1;
    end

    // Feed the chain from the head register; the last cell's word is the tail.
    assign chain_w[0] = head_reg;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lprt_cell #(
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .chain_in  (chain_w[g]),
            .wr        (wr),
            .chain_out (chain_w[g+1])
        );
    end

    // Reject device 0 and devices beyond the configured count.
    assign bad_dev = (tail_reg.dev == 4'd0) || (9'(tail_reg.dev) > DEV_LIMIT);

    // Commit an add: a matching live slot wins over the first free one.
    always_comb
    begin
        wr      = '0;
        wr.idx  = tail_reg.hit ? tail_reg.hit_idx : tail_reg.free_idx;
        wr.net  = tail_reg.net;
        wr.mask = tail_reg.mask;
        wr.gw   = tail_reg.gw;
        wr.dev  = tail_reg.dev;
        wr.plen = tail_reg.plen;
        wr.en   = (state_reg == S_DONE) && out_free && (tail_reg.func == FN_ADD) &&
                  !bad_dev && (tail_reg.hit || tail_reg.free_found);
    end

    // Form the result word from the finished scan.
    always_comb
    begin
        res_status = ST_OK;
        res_device = 4'd0;
        res_hop    = 32'd0;
        unique case (tail_reg.func)
            FN_ADD:
            begin
                if (bad_dev)
                    res_status = ST_BADDEV;
                else if (!tail_reg.hit && !tail_reg.free_found)
                    res_status = ST_FULL;
            end
            FN_LOOKUP:
            begin
                if (tail_reg.best_found)
                begin
                    res_device = tail_reg.best_dev;
                    res_hop    = (tail_reg.best_gw != 32'd0) ? tail_reg.best_gw
                                                             : tail_reg.dest;
                end
                else
                begin
                    res_status = ST_NOROUTE;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            out_device_reg <= 4'd0;
            next_hop_reg   <= 32'd0;
        end
        else
        begin
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // Hold the word leaving the last cell.
                    if (chain_w[ENTRIES].valid)
                    begin
                        tail_reg  <= chain_w[ENTRIES];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        status_reg     <= res_status;
                        out_device_reg <= res_device;
                        next_hop_reg   <= res_hop;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.out_device = out_device_reg;
    assign rsp.next_hop   = next_hop_reg;

endmodule

// ===== sv/lprt_checker.sv =====
// Port checker of the route table, bound to the top level.
`include "longest_prefix_route_table_defines.svh"

module lprt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [3:0]  out_device,
    input logic [31:0] next_hop
);
    import lprt_pkg::*;

    // One word in flight: ready drops after a take.
    `LPRT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)
    // A stalled result stays offered.
    `LPRT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    // Failed operations carry no route.
    `LPRT_ASSERT_NOW(a_fail_empty, clk, rst_n,
        rsp_valid && (status == ST_BADDEV || status == ST_FULL || status == ST_NOROUTE),
        out_device == 4'd0 && next_hop == 32'd0)
    // No result can follow a take in the very next cycle.
    `LPRT_ASSERT_NEXT(a_no_instant, clk, rst_n, req_valid && req_ready && !rsp_valid,
        !rsp_valid)

endmodule

bind longest_prefix_route_table lprt_checker u_lprt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .out_device (rsp.out_device),
    .next_hop   (rsp.next_hop)
);

// ===== tb/longest_prefix_route_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench of the longest prefix route table: directed rows, then random route traffic.
module longest_prefix_route_table_tb;
    import lprt_pkg::*;

    localparam int ENTRIES = 16;
    localparam int DEVICES = 15;

    // Selector value that the block leaves unused; it must answer ok and change nothing.
    localparam logic [1:0] FN_SPARE = 2'd3;

    localparam int POOL_SIZE    = 24;
    localparam int PHASES       = 4;
    localparam int PHASE_WORDS  = 457;
    localparam int STALL_LIMIT  = 2000;
    // One scan through the slot chain plus some margin for a late, unwanted word.
    localparam int DRAIN_CYCLES = ENTRIES + 2 + 16;

    typedef enum int {RX_STEADY, RX_COIN, RX_BURSTY} rx_style_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [3:0]  dev;
    } route_op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_device;
        logic [31:0] next_hop;
    } route_result_t;

    typedef struct packed {
        route_op_t     op;
        logic          typed;
        route_result_t res;
    } directed_row_t;

    // Directed rows. Where typed is set the answer is written out here; the rest are
    // left to the table predictor, which sees every row so that its state keeps step.
    localparam directed_row_t DIRECTED_ROWS [23] = '{
        // loopback route straight after reset
        '{'{FN_LOOKUP, 32'h7F00_0001, 32'h0, 32'h0, 4'h0}, 1'b1,
          '{ST_OK, 4'h1, 32'h7F00_0001}},
        // nothing covers 10/8 yet
        '{'{FN_LOOKUP, 32'h0A00_0001, 32'h0, 32'h0, 4'h0}, 1'b1,
          '{ST_NOROUTE, 4'h0, 32'h0}},
        // add on device zero is refused
        '{'{FN_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 4'h0}, 1'b1,
          '{ST_BADDEV, 4'h0, 32'h0}},
        // unused selector with every bit set
        '{'{FN_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF}, 1'b1,
          '{ST_OK, 4'h0, 32'h0}},
        // default route through a gateway
        '{'{FN_ADD, 32'h0, 32'h0, 32'hC0A8_0001, 4'h2}, 1'b1, '{ST_OK, 4'h0, 32'h0}},
        '{'{FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0}, 1'b1,
          '{ST_OK, 4'h2, 32'hC0A8_0001}},
        // host route, directly attached, on the top device
        '{'{FN_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'hF}, 1'b1,
          '{ST_OK, 4'h0, 32'h0}},
        '{'{FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0}, 1'b1,
          '{ST_OK, 4'hF, 32'hFFFF_FFFF}},
        // a /16 and a non-contiguous mask that also covers its addresses
        '{'{FN_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A00_0001, 4'h3}, 1'b0, '0},
        '{'{FN_ADD, 32'h0A01_0203, 32'hFF00_FF00, 32'h0, 4'h4}, 1'b0, '0},
        '{'{FN_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'h0}, 1'b0, '0},
        // same network and mask again: overwrite in place
        '{'{FN_ADD, 32'h0A01_6363, 32'hFFFF_0000, 32'h0, 4'h5}, 1'b0, '0},
        '{'{FN_LOOKUP, 32'h0A01_0707, 32'h0, 32'h0, 4'h0}, 1'b0, '0},
        // equal prefix length in a later slot: the lower slot must win
        '{'{FN_ADD, 32'h0A01_0000, 32'hFFFF_0001, 32'h0A00_0002, 4'h6}, 1'b0, '0},
        '{'{FN_LOOKUP, 32'h0A01_0008, 32'h0, 32'h0, 4'h0}, 1'b0, '0},
        '{'{FN_LOOKUP, 32'h0A01_0009, 32'h0, 32'h0, 4'h0}, 1'b0, '0},
        // flushes, the empty device first
        '{'{FN_FLUSH, 32'h0, 32'h0, 32'h0, 4'h0}, 1'b1, '{ST_OK, 4'h0, 32'h0}},
        '{'{FN_FLUSH, 32'h0, 32'h0, 32'h0, 4'h5}, 1'b1, '{ST_OK, 4'h0, 32'h0}},
        '{'{FN_LOOKUP, 32'h0A01_0707, 32'h0, 32'h0, 4'h0}, 1'b0, '0},
        // drop the loopback; its addresses fall back to the default route
        '{'{FN_FLUSH, 32'h0, 32'h0, 32'h0, 4'h1}, 1'b1, '{ST_OK, 4'h0, 32'h0}},
        '{'{FN_LOOKUP, 32'h7F00_0001, 32'h0, 32'h0, 4'h0}, 1'b0, '0},
        // alternating mask: one leading one, yet it still beats the default
        '{'{FN_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 4'hA}, 1'b0, '0},
        '{'{FN_LOOKUP, 32'h0, 32'h0, 32'h0, 4'h0}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    lprt_req_if req_bus ();
    lprt_rsp_if rsp_bus ();

    longest_prefix_route_table #(
        .ENTRIES (ENTRIES),
        .DEVICES (DEVICES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Predicted contents of the table, one element per slot.
    logic [3:0]  tbl_dev  [ENTRIES];
    logic [31:0] tbl_net  [ENTRIES];
    logic [31:0] tbl_mask [ENTRIES];
    logic [31:0] tbl_gw   [ENTRIES];
    logic [5:0]  tbl_plen [ENTRIES];

    route_result_t expected_q [$];

    rx_style_t rx_mode     = RX_STEADY;
    int        fail_count  = 0;
    int        idle_cycles = 0;

    int routes_stored  = 0;
    int adds_full      = 0;
    int adds_bad_dev   = 0;
    int lookups_routed = 0;
    int lookups_missed = 0;
    int flushes        = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Count the leading ones of a mask; the bits after the first zero do not count.
    function automatic logic [5:0] leading_ones_of(input logic [31:0] m);
        logic [5:0] n;
        n = 6'd0;
        for (int b = 31; b >= 0; b--)
        begin
            if (!m[b])
                break;
            n++;
        end
        return n;
    endfunction

    // Apply one operation to the predicted table and return the word it should produce.
    function automatic route_result_t route_table_apply(input route_op_t op);
        route_result_t r;
        logic [31:0]   net;
        int            slot;
        int            free_slot;
        int            best;
        r = '{ST_OK, 4'h0, 32'h0};
        case (op.func)
            FN_ADD:
            begin
                net       = op.dest & op.mask;
                slot      = -1;
                free_slot = -1;
                if (op.dev == 4'h0 || op.dev > DEVICES)
                    r.status = ST_BADDEV;
                else
                begin
                    // A live slot with the same network and mask is reused wherever it sits.
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (slot < 0 && tbl_dev[i] != 4'h0 && tbl_net[i] == net &&
                            tbl_mask[i] == op.mask)
                            slot = i;
                        if (free_slot < 0 && tbl_dev[i] == 4'h0)
                            free_slot = i;
                    end
                    if (slot < 0)
                        slot = free_slot;
                    if (slot < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        tbl_net[slot]  = net;
                        tbl_mask[slot] = op.mask;
                        tbl_gw[slot]   = op.gw;
                        tbl_plen[slot] = leading_ones_of(op.mask);
                        tbl_dev[slot]  = op.dev;
                    end
                end
            end
            FN_FLUSH:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_dev[i] == op.dev)
                        tbl_dev[i] = 4'h0;
            end
            FN_LOOKUP:
            begin
                best = -1;
                // Strictly longer prefixes only, so ties stay with the lowest slot.
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_dev[i] != 4'h0 && (op.dest & tbl_mask[i]) == tbl_net[i] &&
                        (best < 0 || tbl_plen[i] > tbl_plen[best]))
                        best = i;
                if (best < 0)
                    r.status = ST_NOROUTE;
                else
                begin
                    r.out_device = tbl_dev[best];
                    r.next_hop   = (tbl_gw[best] != 32'h0) ? tbl_gw[best] : op.dest;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Predict one accepted word, queue its answer and keep the tallies for the summary.
    function automatic void expect_word(input route_op_t op, input logic typed,
                                        input route_result_t typed_res);
        route_result_t predicted;
        predicted = route_table_apply(op);
        expected_q.push_back(typed ? typed_res : predicted);
        case (op.func)
            FN_ADD:
            begin
                if (predicted.status == ST_OK)
                    routes_stored++;
                else if (predicted.status == ST_FULL)
                    adds_full++;
                else
                    adds_bad_dev++;
            end
            FN_LOOKUP:
            begin
                if (predicted.status == ST_OK)
                    lookups_routed++;
                else
                    lookups_missed++;
            end
            FN_FLUSH:
                flushes++;
            default:
            begin
            end
        endcase
    endfunction

    // Present one request word and hold it until the edge at which it is taken.
    task automatic send_word(input route_op_t op);
        req_bus.valid     <= 1'b1;
        req_bus.func      <= op.func;
        req_bus.dest_addr <= op.dest;
        req_bus.addr_mask <= op.mask;
        req_bus.gateway   <= op.gw;
        req_bus.device    <= op.dev;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    // Receiver: always ready, a coin toss per cycle, or long runs of ready and stall.
    initial
    begin
        int run;
        bit hold_ready;
        run        = 0;
        hold_ready = 1'b0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            case (rx_mode)
                RX_STEADY:
                    rsp_bus.ready <= 1'b1;
                RX_COIN:
                    rsp_bus.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (run == 0)
                    begin
                        hold_ready = !hold_ready;
                        run = hold_ready ? $urandom_range(1, 8) : $urandom_range(1, 30);
                    end
                    run--;
                    rsp_bus.ready <= hold_ready;
                end
            endcase
        end
    end

    // Compare each result word taken with the oldest answer waiting.
    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result word with no request waiting: status %0d device %0d hop %h",
                       rsp_bus.status, rsp_bus.out_device, rsp_bus.next_hop);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                    fail_count++;
                end
                if (rsp_bus.out_device !== want.out_device)
                begin
                    $error("out_device: expected %0d, got %0d",
                           want.out_device, rsp_bus.out_device);
                    fail_count++;
                end
                if (rsp_bus.next_hop !== want.next_hop)
                begin
                    $error("next_hop: expected %h, got %h", want.next_hop, rsp_bus.next_hop);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_q.size());
            $display("longest_prefix_route_table_tb NOT OK");
            $finish;
        end
    end

    // Stimulus: reset, the directed rows, then random phases of route traffic.
    initial
    begin
        route_op_t   op;
        logic [31:0] pool_net  [POOL_SIZE];
        logic [31:0] pool_mask [POOL_SIZE];
        int          plen;
        int          pick;
        int          roll;
        int          dev_hi;
        int          burst_left;
        bit          sender_gaps;

        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.func      = FN_ADD;
        req_bus.dest_addr = 32'h0;
        req_bus.addr_mask = 32'h0;
        req_bus.gateway   = 32'h0;
        req_bus.device    = 4'h0;

        // Reset leaves only the loopback route in slot 0.
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_dev[i]  = 4'h0;
            tbl_net[i]  = 32'h0;
            tbl_mask[i] = 32'h0;
            tbl_gw[i]   = 32'h0;
            tbl_plen[i] = 6'd0;
        end
        tbl_dev[0]  = LOOP_DEV;
        tbl_net[0]  = LOOP_NET;
        tbl_mask[0] = LOOP_MASK;
        tbl_plen[0] = LOOP_PLEN;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows back to back against a receiver that stalls at random.
        rx_mode = RX_COIN;
        foreach (DIRECTED_ROWS[r])
        begin
            send_word(DIRECTED_ROWS[r].op);
            expect_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
        end

        burst_left = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // First phase runs flat out; the others add sender gaps and receiver stalls.
            sender_gaps = (ph != 0);
            rx_mode     = (ph == 0) ? RX_STEADY : ((ph % 2) ? RX_COIN : RX_BURSTY);
            // Few devices make flushes sweep many slots; all devices exercise every bit.
            dev_hi      = (ph % 2) ? DEVICES : 4;

            // Build a fresh pool of prefixes, some nested inside the one before, so that
            // lookups see several matching routes of different lengths. More prefixes
            // than slots keep the table close to full.
            for (int k = 0; k < POOL_SIZE; k++)
            begin
                plen = $urandom_range(0, 32);
                pool_mask[k] = (plen == 0) ? 32'h0 : (~32'h0 << (32 - plen));
                if ($urandom_range(0, 7) == 0)
                    pool_mask[k] = $urandom;
                if (k > 0 && $urandom_range(0, 2) == 0)
                begin
                    pool_mask[k] = pool_mask[k] | pool_mask[k - 1];
                    pool_net[k]  = pool_net[k - 1] |
                                   ($urandom & pool_mask[k] & ~pool_mask[k - 1]);
                end
                else
                    pool_net[k] = $urandom & pool_mask[k];
            end

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (burst_left == 0)
                begin
                    if (sender_gaps)
                    begin
                        req_bus.valid <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;

                pick    = $urandom_range(0, POOL_SIZE - 1);
                op.dest = $urandom;
                op.mask = pool_mask[pick];
                op.gw   = ($urandom_range(0, 2) == 0) ? 32'h0 : 32'($urandom);
                op.dev  = 4'($urandom_range(1, dev_hi));
                if ($urandom_range(0, 19) == 0)
                    op.dev = 4'h0;

                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    // Pool route with random host bits, which the table must mask off.
                    op.func = FN_ADD;
                    op.dest = pool_net[pick] | (op.dest & ~pool_mask[pick]);
                end
                else if (roll < 85)
                begin
                    // Mostly addresses inside a pool prefix; the rest anywhere.
                    op.func = FN_LOOKUP;
                    if (roll < 75)
                        op.dest = pool_net[pick] | (op.dest & ~pool_mask[pick]);
                end
                else if (roll < 92)
                    op.func = FN_FLUSH;
                else if (roll < 95)
                    op.func = FN_SPARE;
                else
                begin
                    // Noise: every field drawn at random.
                    op.func = 2'($urandom_range(0, 3));
                    op.mask = $urandom;
                    op.gw   = $urandom;
                    op.dev  = 4'($urandom_range(0, 15));
                end

                send_word(op);
                expect_word(op, 1'b0, '0);
            end
        end

        // Drain: wait for every answer, then allow one more scan for stray words.
        req_bus.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("adds: %0d stored, %0d refused on a full table, %0d on a bad device; %0d flushes",
                 routes_stored, adds_full, adds_bad_dev, flushes);
        $display("lookups: %0d routed, %0d without a route; %0d mismatches",
                 lookups_routed, lookups_missed, fail_count);
        if (fail_count == 0)
            $display("longest_prefix_route_table_tb OK");
        else
            $display("longest_prefix_route_table_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lprt_pkg.sv
sv/lprt_req_if.sv
sv/lprt_rsp_if.sv
sv/lprt_cell.sv
sv/longest_prefix_route_table.sv
sv/lprt_checker.sv
tb/longest_prefix_route_table_tb.sv
